// ----- rtl/xpg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xpg_pkg: shared types and constants of the xorshift pattern engine
// Register indexes, the configuration and result records, and the
// xorshift32 step function used by the pattern engine.
// ----------------------------------------------------------------------------
package xpg_pkg;

    // Field widths
    localparam int unsigned SEED_W   = 32;
    localparam int unsigned LEN_W    = 24;
    localparam int unsigned OFF_W    = 23;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned CFG_IDX_W = 2;

    // Default longest run, in bytes
    localparam int unsigned MAX_RUN_DEFAULT = 32'd8388608;

    // Xorshift32 shift amounts
    localparam int unsigned XS_SHL_A = 13;
    localparam int unsigned XS_SHR_B = 17;
    localparam int unsigned XS_SHL_C = 5;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEED       = 2'd0,
        REG_RUN_LENGTH = 2'd1,
        REG_MODE       = 2'd2
    } t_reg_idx;

    // Current configuration, as seen by the engine
    typedef struct packed {
        logic [SEED_W-1:0] seed;
        logic [LEN_W-1:0]  run_length;
        logic              mode;
    } t_cfg;

    // One result record
    typedef struct packed {
        logic [BYTE_W-1:0] pattern_byte;
        logic              mismatch;
        logic [OFF_W-1:0]  first_diff_offset;
        logic              diff_found;
        logic              last;
        logic              status;
    } t_result;

    // One step of the xorshift32 generator
    function automatic logic [SEED_W-1:0] xs_step(input logic [SEED_W-1:0] x);
        logic [SEED_W-1:0] a;
        logic [SEED_W-1:0] b;
        a = x ^ (x << XS_SHL_A);
        b = a ^ (a >> XS_SHR_B);
        return b ^ (b << XS_SHL_C);
    endfunction

endpackage

// ----- rtl/xpg_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xpg_engine: generator state, run counter and mismatch record
// Steps the xorshift32 state once per request, compares the incoming byte
// in verify mode and tracks the first mismatch offset of the current run.
// ----------------------------------------------------------------------------
module xpg_engine #(
    parameter int unsigned MAX_RUN = xpg_pkg::MAX_RUN_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  xpg_pkg::t_cfg               i_cfg,
    input  logic                        i_step,
    input  logic                        i_start,
    input  logic [xpg_pkg::BYTE_W-1:0]  i_data,
    output xpg_pkg::t_result            o_res
);
    import xpg_pkg::*;

    // Longest run that the length counter must honor
    localparam logic [32:0]      MaxRunW = 33'(MAX_RUN);
    localparam logic [LEN_W-1:0] MaxLen  =
        (MaxRunW > 33'(24'hFFFFFF)) ? 24'hFFFFFF : MaxRunW[LEN_W-1:0];

    logic [SEED_W-1:0] r_gen;
    logic [LEN_W-1:0]  r_off;
    logic [LEN_W-1:0]  r_fd;
    logic              r_found;

    logic [SEED_W-1:0] n_gen;
    logic [LEN_W-1:0]  n_off;
    logic [LEN_W-1:0]  n_fd;
    logic              n_found;

    logic [SEED_W-1:0] w_seeded;
    logic [SEED_W-1:0] w_cur_gen;
    logic [LEN_W-1:0]  w_cur_off;
    logic [LEN_W-1:0]  w_cur_fd;
    logic              w_cur_found;
    logic [SEED_W-1:0] w_stepped;
    logic              w_miss;
    logic              w_found;
    logic [LEN_W-1:0]  w_fd;
    logic [LEN_W-1:0]  w_eff_len;
    logic              w_last;

    // Zero seed would lock the generator, so it loads all ones instead
    assign w_seeded = (i_cfg.seed == '0) ? '1 : i_cfg.seed;

    // Clamp the run length into one..longest run
    always_comb begin
        if (i_cfg.run_length == '0) begin
            w_eff_len = LEN_W'(1);
        end else if (i_cfg.run_length > MaxLen) begin
            w_eff_len = MaxLen;
        end else begin
            w_eff_len = i_cfg.run_length;
        end
    end

    // A start request restarts the run on this same byte
    assign w_cur_gen   = i_start ? w_seeded : r_gen;
    assign w_cur_off   = i_start ? '0 : r_off;
    assign w_cur_fd    = i_start ? '0 : r_fd;
    assign w_cur_found = i_start ? 1'b0 : r_found;

    // Step, compare and update the mismatch record
    assign w_stepped = xs_step(w_cur_gen);
    assign w_miss    = i_cfg.mode && (i_data != w_stepped[BYTE_W-1:0]);
    assign w_found   = w_cur_found | w_miss;
    assign w_fd      = (w_miss && !w_cur_found) ? w_cur_off : w_cur_fd;
    assign w_last    = ({1'b0, w_cur_off} + (LEN_W+1)'(1)) >= {1'b0, w_eff_len};

    // Result of this byte
    always_comb begin
        o_res.pattern_byte      = w_stepped[BYTE_W-1:0];
        o_res.mismatch          = w_miss;
        o_res.first_diff_offset = w_found ? w_fd[OFF_W-1:0] : '0;
        o_res.diff_found        = w_found;
        o_res.last              = w_last;
        o_res.status            = w_last & w_found;
    end

    // After the last byte the run restarts from the seed
    always_comb begin
        if (w_last) begin
            n_gen   = w_seeded;
            n_off   = '0;
            n_fd    = '0;
            n_found = 1'b0;
        end else begin
            n_gen   = w_stepped;
            n_off   = w_cur_off + LEN_W'(1);
            n_fd    = w_fd;
            n_found = w_found;
        end
    end

    // Engine state; reset seed is zero, so the generator starts at all ones
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen   <= '1;
            r_off   <= '0;
            r_fd    <= '0;
            r_found <= 1'b0;
        end else if (i_step) begin
            r_gen   <= n_gen;
            r_off   <= n_off;
            r_fd    <= n_fd;
            r_found <= n_found;
        end
    end

endmodule

// ----- rtl/xorshift_pattern_gen_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xorshift_pattern_gen_check: memory-test pattern generator and checker
// Produces an xorshift32 byte pattern and, in verify mode, checks read-back
// bytes against it, reporting the first mismatch offset of each run.
// ----------------------------------------------------------------------------
// The block takes one byte request per clock cycle while the output is not
// stalled and returns one result per request, in order. The input register
// and the output register each hold one request, and the single xorshift
// step plus byte compare between them sets that rate. Set tuser on a request
// to reload the generator from the seed and begin a new run at that byte;
// otherwise a run restarts by itself after its last byte, so consecutive runs
// repeat the same pattern. Write configuration only while no request
// is in flight.
// ----------------------------------------------------------------------------
module xorshift_pattern_gen_check #(
    parameter int unsigned MAX_RUN = xpg_pkg::MAX_RUN_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port
    input  logic                           i_cfg_we,
    input  logic [xpg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [xpg_pkg::CFG_W-1:0]      i_cfg_data,
    // Request stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
    input  logic                           s_axis_tuser,   // [0] start_req
    // Result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,   // [7:0] pattern_byte,
                                                           // [30:8] first_diff_offset,
                                                           // [31] zero
    output logic [2:0]                     m_axis_tuser,   // [0] mismatch,
                                                           // [1] diff_found, [2] status
    output logic                           m_axis_tlast
);
    import xpg_pkg::*;

    t_cfg            r_cfg;
    logic            r_in_valid;
    logic            r_in_start;
    logic [BYTE_W-1:0] r_in_data;
    logic            r_out_valid;
    t_result         r_out;

    logic            w_out_free;
    logic            w_step;
    t_result         w_res;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seed       <= '0;
            r_cfg.run_length <= LEN_W'(1);
            r_cfg.mode       <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SEED:       r_cfg.seed       <= i_cfg_data[SEED_W-1:0];
                REG_RUN_LENGTH: r_cfg.run_length <= i_cfg_data[LEN_W-1:0];
                REG_MODE:       r_cfg.mode       <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Handshake: output slot frees on take, input slot frees on step
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_start <= s_axis_tuser;
            r_in_data  <= s_axis_tdata;
        end
    end

    // Generator and checker
    xpg_engine #(
        .MAX_RUN (MAX_RUN)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_step  (w_step),
        .i_start (r_in_start),
        .i_data  (r_in_data),
        .o_res   (w_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    // Result stream packing
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.first_diff_offset, r_out.pattern_byte};
    assign m_axis_tuser  = {r_out.status, r_out.diff_found, r_out.mismatch};
    assign m_axis_tlast  = r_out.last;

    // A stepped request always lands in the output register
    a_step_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("stepped request did not reach the output register");

    // A held request is never dropped while the output is blocked
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_free) |=> r_in_valid)
        else $error("pending request lost while output stalled");

    // A failing status only comes on the last byte of a run with a mismatch
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_res.status) |-> (w_res.last && w_res.diff_found))
        else $error("status set outside the last byte of a failing run");

    // A mismatch on this byte is always recorded
    a_miss_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_res.mismatch) |-> w_res.diff_found)
        else $error("mismatch not recorded in diff_found");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for xorshift_pattern_gen_check
// Drives byte requests in random bursts against a stalling result receiver.
// A scoreboard runs its own xorshift32 engine over every accepted request.
// It checks each result field against that engine and covers register
// writes between phases, mid-run changes, and verify runs with bad bytes.
// ----------------------------------------------------------------------------
module testbench;

    import xpg_pkg::*;

    localparam int unsigned CLK_PERIOD   = 4;
    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned ITEMS        = 550;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RUN_CAP      = MAX_RUN_DEFAULT;

    // Index with no register behind it; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_LONG} t_rx_style;

    typedef struct {
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     value;
    } t_reg_write;

    // ------------------------------------------------------------------------
    // Scoreboard: its own pattern engine plus the queue of results still due.
    // ------------------------------------------------------------------------
    class xpg_scoreboard;
        logic [31:0] seed_r;
        logic [23:0] length_r;
        logic        mode_r;
        logic [31:0] gen_r;
        int unsigned offset_r;
        int unsigned first_diff_r;
        bit          found_r;
        t_result     due_results[$];
        int unsigned errors;
        int unsigned n_requests;
        int unsigned n_results;
        int unsigned n_runs;
        int unsigned n_failed_runs;
        int unsigned n_writes;

        function new();
            seed_r        = '0;
            length_r      = 24'd1;
            mode_r        = 1'b0;
            errors        = 0;
            n_requests    = 0;
            n_results     = 0;
            n_runs        = 0;
            n_failed_runs = 0;
            n_writes      = 0;
            reload();
        endfunction

        function logic [31:0] xorshift(logic [31:0] x);
            logic [31:0] y;
            y = x ^ (x << 13);
            y = y ^ (y >> 17);
            return y ^ (y << 5);
        endfunction

        // A zero seed would lock the generator, so all ones stands in for it.
        function logic [31:0] seed_state();
            return (seed_r == '0) ? 32'hFFFF_FFFF : seed_r;
        endfunction

        function void reload();
            gen_r        = seed_state();
            offset_r     = 0;
            first_diff_r = 0;
            found_r      = 1'b0;
        endfunction

        // Zero length acts as one byte; anything past the cap is clamped.
        function int unsigned run_bytes();
            if (length_r == '0) return 1;
            if (length_r > RUN_CAP) return RUN_CAP;
            return length_r;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            n_writes++;
            case (idx)
                REG_SEED:       seed_r   = value;
                REG_RUN_LENGTH: length_r = value[23:0];
                REG_MODE:       mode_r   = value[0];
                default: ;
            endcase
        endfunction

        // Pattern byte the next request would be compared with.
        function logic [7:0] upcoming(logic start);
            logic [31:0] x;
            x = start ? seed_state() : gen_r;
            x = xorshift(x);
            return x[7:0];
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        function void note_request(logic start, logic [7:0] data);
            t_result r;
            n_requests++;
            if (start) reload();
            gen_r = xorshift(gen_r);
            r.pattern_byte = gen_r[7:0];
            r.mismatch     = mode_r && (data != gen_r[7:0]);
            if (r.mismatch && !found_r) begin
                found_r      = 1'b1;
                first_diff_r = offset_r;
            end
            r.last              = (offset_r + 1 >= run_bytes());
            r.diff_found        = found_r;
            r.first_diff_offset = found_r ? 23'(first_diff_r) : '0;
            r.status            = r.last ? found_r : 1'b0;
            due_results.push_back(r);
            if (r.last) reload();
            else offset_r++;
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("[%0t] result %0d: %s expected %0h, got %0h",
                             $time, n_results, field, want, got);
            end
        endfunction

        function void check_result(logic [31:0] tdata, logic [2:0] tuser, logic tlast);
            t_result want;
            n_results++;
            if (due_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("[%0t] result %0d with no request outstanding: tdata %h tuser %b",
                             $time, n_results, tdata, tuser);
                return;
            end
            want = due_results.pop_front();
            if (want.last) begin
                n_runs++;
                if (want.status) n_failed_runs++;
            end
            compare("pattern_byte", want.pattern_byte, tdata[7:0]);
            compare("first_diff_offset", want.first_diff_offset, tdata[30:8]);
            compare("tdata pad bit", 1'b0, tdata[31]);
            compare("mismatch", want.mismatch, tuser[0]);
            compare("diff_found", want.diff_found, tuser[1]);
            compare("status", want.status, tuser[2]);
            compare("last", want.last, tlast);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test.
    // ------------------------------------------------------------------------
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;   // [7:0] data_byte
    logic                 s_axis_tuser  = 1'b0; // [0] start_req
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;         // [7:0] pattern_byte, [30:8] first_diff_offset
    logic [2:0]           m_axis_tuser;         // [0] mismatch, [1] diff_found, [2] status
    logic                 m_axis_tlast;

    xpg_scoreboard sb = new();

    t_reg_write  reg_writes[$];
    int unsigned burst_left = 0;
    bit          gaps_on    = 1'b1;
    t_rx_style   rx_style   = RX_OPEN;
    int unsigned rx_tick    = 0;
    int unsigned cycle_count = 0;

    xorshift_pattern_gen_check dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    // Receiver backpressure; the style changes from phase to phase.
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        case (rx_style)
            RX_OPEN:     m_axis_tready <= 1'b1;
            RX_COIN:     m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_axis_tready <= ((rx_tick % 7) > 1);
            default:     m_axis_tready <= ((rx_tick % 48) >= 15);
        endcase
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, sb.pending());
            $display("xorshift_pattern_gen_check verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks.
    // ------------------------------------------------------------------------

    // One byte request; a new burst may start with an idle gap.
    task automatic send_byte(input logic start, input logic [7:0] data);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(start, data);
        burst_left--;
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic void queue_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        t_reg_write w;
        w.idx   = idx;
        w.value = value;
        reg_writes.push_back(w);
    endfunction

    // Issue the queued register writes back to back, then drop the enable.
    task automatic flush_writes();
        t_reg_write w;
        while (reg_writes.size() != 0) begin
            w = reg_writes.pop_front();
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= w.idx;
            i_cfg_data <= w.value;
            @(posedge i_clk);
            sb.note_config(w.idx, w.value);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Random settings; unused high bits of the data word carry junk.
    task automatic random_config();
        logic [31:0] seed_v;
        logic [31:0] len_v;
        logic [31:0] mode_v;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       seed_v = '0;
            1:       seed_v = 32'hFFFF_FFFF;
            2:       seed_v = 32'h8000_0000;
            default: seed_v = $urandom();
        endcase
        pick = $urandom_range(0, 19);
        if (pick == 0)      len_v = 0;
        else if (pick == 1) len_v = $urandom_range(RUN_CAP, 24'hFF_FFFF);
        else if (pick < 5)  len_v = $urandom_range(17, 64);
        else                len_v = $urandom_range(1, 16);
        len_v[31:24] = 8'($urandom());
        mode_v    = $urandom();
        mode_v[0] = ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 2) != 0) queue_write(REG_SEED, seed_v);
        if ($urandom_range(0, 2) != 0) queue_write(REG_RUN_LENGTH, len_v);
        if ($urandom_range(0, 7) == 0) queue_write(REG_UNUSED, $urandom());
        if (reg_writes.size() == 0 || $urandom_range(0, 2) != 0)
            queue_write(REG_MODE, mode_v);
        flush_writes();
    endtask

    // Mostly well-formed runs with the odd bad byte or restart; noisy
    // phases throw random bytes and restarts at the block.
    task automatic random_phase(input int unsigned n_items, input bit noisy);
        logic       start;
        logic [7:0] data;
        for (int unsigned i = 0; i < n_items; i++) begin
            if (noisy) begin
                start = ($urandom_range(0, 3) == 0);
                data  = $urandom_range(0, 255);
            end else begin
                start = (i == 0 && $urandom_range(0, 1) == 1) || ($urandom_range(0, 29) == 0);
                data  = sb.upcoming(start);
                if ($urandom_range(0, 15) == 0)
                    data = data ^ 8'($urandom_range(1, 255));
            end
            send_byte(start, data);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] data;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults after reset: zero seed, one-byte runs, generate mode.
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b1, 8'hA5);
        drain();

        // Clean four-byte verify run from the smallest nonzero seed.
        queue_write(REG_SEED, 32'h0000_0001);
        queue_write(REG_RUN_LENGTH, 32'd4);
        queue_write(REG_MODE, 32'h0000_0001);
        flush_writes();
        for (int i = 0; i < 4; i++) send_byte(i == 0, sb.upcoming(i == 0));
        // Same run with bad bytes at the last two offsets; the first is kept.
        for (int i = 0; i < 4; i++) begin
            data = sb.upcoming(i == 0);
            if (i >= 2) data = ~data;
            send_byte(i == 0, data);
        end
        drain();

        // Zero length acts as one byte; a write to the spare index is dropped.
        queue_write(REG_RUN_LENGTH, 32'hFF00_0000);
        queue_write(REG_UNUSED, 32'hFFFF_FFFF);
        flush_writes();
        send_byte(1'b0, 8'h00);
        send_byte(1'b1, sb.upcoming(1'b1));
        drain();

        // All-ones seed, length past the cap, generate mode with junk high bits.
        queue_write(REG_SEED, 32'hFFFF_FFFF);
        queue_write(REG_RUN_LENGTH, 32'h00FF_FFFF);
        queue_write(REG_MODE, 32'hFFFF_FFFE);
        flush_writes();
        for (int i = 0; i < 5; i++) send_byte(i == 0, $urandom_range(0, 255));
        drain();

        // Shorten the run below the current offset: the next byte closes it.
        queue_write(REG_RUN_LENGTH, 32'd2);
        flush_writes();
        send_byte(1'b0, 8'h3C);
        drain();

        // New seed and verify mode mid-run; the generator runs on to the end.
        queue_write(REG_RUN_LENGTH, 32'd4);
        flush_writes();
        send_byte(1'b0, 8'h5A);
        send_byte(1'b0, 8'hC3);
        drain();
        queue_write(REG_SEED, 32'h8000_0000);
        queue_write(REG_MODE, 32'h0000_0001);
        flush_writes();
        send_byte(1'b0, ~sb.upcoming(1'b0));
        send_byte(1'b0, sb.upcoming(1'b0));
        send_byte(1'b0, sb.upcoming(1'b0));
        drain();

        // Longest legal run length.
        queue_write(REG_RUN_LENGTH, RUN_CAP);
        flush_writes();
        send_byte(1'b1, sb.upcoming(1'b1));
        send_byte(1'b0, 8'h00);
        drain();

        // Random phases, each with its own settings and idling styles.
        while (sb.n_requests < ITEMS) begin
            random_config();
            gaps_on  = ($urandom_range(0, 3) != 0);
            rx_style = t_rx_style'($urandom_range(0, 3));
            random_phase($urandom_range(10, 40), $urandom_range(0, 5) == 0);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d byte requests and checked %0d results over %0d finished runs.",
                 sb.n_requests, sb.n_results, sb.n_runs);
        $display("%0d runs ended with a verify mismatch; %0d register writes; %0d bad fields.",
                 sb.n_failed_runs, sb.n_writes, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("xorshift_pattern_gen_check verification clean");
        end else begin
            $display("xorshift_pattern_gen_check verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/xpg_pkg.sv
rtl/xpg_engine.sv
rtl/xorshift_pattern_gen_check.sv
tb/testbench.sv
